FILE: rtl/core/msh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msh_pkg: shared types and constants for the mid-square hash insert unit
// Holds the fixed field widths, operation codes, sequencer states and the
// status/control bundles passed between the sequencer and its units.
// ----------------------------------------------------------------------------
package msh_pkg;

	// Fixed payload widths
	localparam int KEY_W   = 16;
	localparam int SLOT_W  = 4;
	localparam int PROBE_W = 5;

	// Decimal digits needed for a square of up to 32 bits
	localparam int NDIG     = 10;
	localparam int DIG_IDXW = 4;

	// Two-digit hash values span 0 to 99
	localparam int MID_SPAN = 100;
	localparam int MID_W    = 7;

	// Operation codes
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_CONV,
		ST_PICK,
		ST_HASH,
		ST_PROBE,
		ST_RD,
		ST_FETCH,
		ST_DONE
	} msh_state_t;

	// Status of the binary-to-decimal converter
	typedef struct packed {
		logic busy;
		logic done;
	} bcd_stat_t;

	// Access strobes into the slot table
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} tbl_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/msh_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msh_if: request and response channels of the mid-square hash insert unit
// Valid/ready channels; an item moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface msh_req_if;
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic [msh_pkg::KEY_W-1:0]  key;
	logic [msh_pkg::SLOT_W-1:0] slot_sel;

	modport source (output valid, func, key, slot_sel, input ready);
	modport sink   (input valid, func, key, slot_sel, output ready);
endinterface

interface msh_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [msh_pkg::SLOT_W-1:0]  slot;
	logic [msh_pkg::SLOT_W-1:0]  home_slot;
	logic [msh_pkg::KEY_W-1:0]   stored_key;
	logic                        occupied;
	logic [msh_pkg::PROBE_W-1:0] probe_count;
	logic                        table_full;

	modport source (output valid, slot, home_slot, stored_key, occupied, probe_count,
		table_full, input ready);
	modport sink   (input valid, slot, home_slot, stored_key, occupied, probe_count,
		table_full, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/msh_bcd_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msh_bcd_unit: iterative binary to decimal converter
// Shift-and-add-3 conversion, one input bit per cycle.
// ----------------------------------------------------------------------------
module msh_bcd_unit #(
	parameter int IN_W = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	input  wire logic [IN_W-1:0]                        value,
	output msh_pkg::bcd_stat_t                          stat,
	output logic [msh_pkg::NDIG-1:0][3:0]               digits
);
	import msh_pkg::*;

	localparam int CW = $clog2(IN_W + 1);

	logic [IN_W-1:0]        sh_q;
	logic [NDIG-1:0][3:0]   bcd_q;
	logic [NDIG-1:0][3:0]   adj;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q;
	logic                   done_q;

	// Correct every digit that would overflow on the next doubling
	always_comb begin
		for (int d = 0; d < NDIG; d++) begin
			adj[d] = (bcd_q[d] >= 4'd5) ? bcd_q[d] + 4'd3 : bcd_q[d];
		end
	end

	// Sequence the conversion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(IN_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Shift binary bits into the decimal register
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			sh_q  <= {sh_q[IN_W-2:0], 1'b0};
			bcd_q <= {adj[NDIG-1][2:0], adj[NDIG-2:0], sh_q[IN_W-1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign digits    = bcd_q;

	// Completion only follows a running conversion
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> $past(busy_q))
		else $error("conversion done without a running conversion");

endmodule
`default_nettype wire

FILE: rtl/core/msh_slot_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msh_slot_table: slot storage of the hash table
// Key memory with one write and one registered read port, plus per-slot
// occupied flags that reset clears.
// ----------------------------------------------------------------------------
module msh_slot_table #(
	parameter int TABLE_SLOTS = 16,
	parameter int KEY_BITS    = 16,
	parameter int IDX_W       = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire msh_pkg::tbl_ctl_t    ctl,
	input  wire logic [IDX_W-1:0]     wr_idx,
	input  wire logic [KEY_BITS-1:0]  wr_key,
	input  wire logic [IDX_W-1:0]     rd_idx,
	output logic [KEY_BITS-1:0]       rd_key,
	input  wire logic [IDX_W-1:0]     chk_idx,
	output logic                      chk_valid
);
	import msh_pkg::*;

	logic [KEY_BITS-1:0]    mem_q [TABLE_SLOTS];
	logic [KEY_BITS-1:0]    rd_key_q;
	logic [TABLE_SLOTS-1:0] valid_q;

	// Mark slots as they are filled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	// Write and read the key memory
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_idx] <= wr_key;
		end
		if (ctl.rd_en) begin
			rd_key_q <= mem_q[rd_idx];
		end
	end

	assign rd_key    = rd_key_q;
	assign chk_valid = valid_q[chk_idx];

	// A write never lands on an occupied slot
	a_wr_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |-> !valid_q[wr_idx])
		else $error("write into an occupied slot");

	// A written slot reads as occupied afterwards
	a_wr_marks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |=> valid_q[$past(wr_idx)])
		else $error("written slot not marked occupied");

endmodule
`default_nettype wire

FILE: rtl/core/mid_square_hash_linear_probe_insert_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mid_square_hash_linear_probe_insert_unit: mid-square hash table insert
// Squares a key, hashes it on the middle decimal digits and inserts it by
// linear probing; a read request returns the contents of one slot.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item: func (0 insert key, 1 read slot slot_sel), key and
//   slot_sel. rsp returns exactly one result item per request.
//   An insert squares the key, runs the serial decimal conversion of the square
//   until its done flag (key bits at most 16), picks the middle digits and
//   reduces them to a slot, then visits slots in the probe sequencer, fetches
//   the home key when the table is full and loads the output register.
//   A read does a memory read, a fetch and an output load.
//   The unit takes one item at a time: req.ready is high only while the
//   sequencer is idle. The output register lets the next item be accepted
//   while a result still waits; a stalled rsp holds its item and the
//   sequencer waits in its final state until the register frees up.
//   Reset empties the table (all slots free) and drops any item in flight.
// ----------------------------------------------------------------------------
module mid_square_hash_linear_probe_insert_unit #(
	parameter int TABLE_SLOTS = 16,
	parameter int KEY_WIDTH   = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	msh_req_if.sink    req,
	msh_rsp_if.source  rsp
);
	import msh_pkg::*;

	localparam int KB    = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
	localparam int SQ_W  = 2 * KB;
	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

	msh_state_t            state_q, state_d;

	logic                  func_q;
	logic [KB-1:0]         key_q;
	logic [SLOT_W-1:0]     sel_q;
	logic [MID_W-1:0]      mid_q;
	logic [IDX_W-1:0]      home_q;
	logic [IDX_W-1:0]      idx_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  full_q;

	logic                  req_acc;
	logic                  out_load;
	logic                  out_valid_q;

	logic                  bcd_start;
	logic [SQ_W-1:0]       sq_c;
	bcd_stat_t             bcd_stat;
	logic [NDIG-1:0][3:0]  digits;

	tbl_ctl_t              tbl_ctl;
	logic [IDX_W-1:0]      sel_idx;
	logic [IDX_W-1:0]      rd_idx;
	logic [IDX_W-1:0]      chk_idx;
	logic [KB-1:0]         rd_key;
	logic                  chk_valid;
	logic                  probe_last;
	logic                  sel_ok;

	logic [DIG_IDXW-1:0]   len_c;
	logic [DIG_IDXW-1:0]   half_c;
	logic [DIG_IDXW-1:0]   hi_i;
	logic [DIG_IDXW-1:0]   lo_i;
	logic [MID_W-1:0]      mid_c;
	logic [IDX_W-1:0]      mod_lut [MID_SPAN];

	logic [SLOT_W-1:0]     slot_c;
	logic [SLOT_W-1:0]     home_c;
	logic [KEY_W-1:0]      skey_c;
	logic                  occ_c;
	logic [PROBE_W-1:0]    probes_c;
	logic                  full_c;

	logic [SLOT_W-1:0]     slot_q;
	logic [SLOT_W-1:0]     home_slot_q;
	logic [KEY_W-1:0]      skey_q;
	logic                  occ_q;
	logic [PROBE_W-1:0]    probes_q;
	logic                  tfull_q;

	// Two-digit value to slot, reduced at elaboration
	for (genvar g = 0; g < MID_SPAN; g++) begin : g_mod
		assign mod_lut[g] = IDX_W'(g % TABLE_SLOTS);
	end

	assign req_acc    = req.valid && req.ready;
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
	assign probe_last = (cnt_q == CNT_W'(TABLE_SLOTS - 1));
	assign sel_idx    = IDX_W'(sel_q);
	assign sel_ok     = (32'(sel_q) < 32'(TABLE_SLOTS));
	assign sq_c       = SQ_W'(key_q) * SQ_W'(key_q);

	// Advance the sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (req_acc) state_d = (req.func == FUNC_READ) ? ST_RD : ST_MUL;
			ST_MUL:   state_d = ST_CONV;
			ST_CONV:  if (bcd_stat.done) state_d = ST_PICK;
			ST_PICK:  state_d = ST_HASH;
			ST_HASH:  state_d = ST_PROBE;
			ST_PROBE: begin
				if (!chk_valid) state_d = ST_DONE;
				else if (probe_last) state_d = ST_FETCH;
			end
			ST_RD:    state_d = ST_FETCH;
			ST_FETCH: state_d = ST_DONE;
			ST_DONE:  if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Drive strobes from the current state
	always_comb begin
		req.ready     = 1'b0;
		bcd_start     = 1'b0;
		tbl_ctl.wr_en = 1'b0;
		tbl_ctl.rd_en = 1'b0;
		unique case (state_q)
			ST_IDLE:  req.ready = 1'b1;
			ST_MUL:   bcd_start = 1'b1;
			ST_PROBE: begin
				tbl_ctl.wr_en = !chk_valid;
				tbl_ctl.rd_en = chk_valid && probe_last;
			end
			ST_RD:    tbl_ctl.rd_en = 1'b1;
			default:  ;
		endcase
	end

	assign rd_idx  = (func_q == FUNC_READ) ? sel_idx : home_q;
	assign chk_idx = (func_q == FUNC_READ) ? sel_idx : idx_q;

	// Locate the two middle digits of the square, or its only digit if it has one
	always_comb begin
		len_c = DIG_IDXW'(1);
		for (int d = 1; d < NDIG; d++) begin
			if (digits[d] != 4'd0) len_c = DIG_IDXW'(d + 1);
		end
		half_c = len_c >> 1;
		hi_i   = len_c - half_c;
		lo_i   = len_c - half_c - DIG_IDXW'(1);
		if (len_c == DIG_IDXW'(1)) begin
			mid_c = MID_W'(digits[0]);
		end else begin
			mid_c = MID_W'({digits[hi_i], 3'b000}) + MID_W'({digits[hi_i], 1'b0})
				+ MID_W'(digits[lo_i]);
		end
	end

	// Hold the item and walk the probe
	always_ff @(posedge clk) begin
		if (req_acc) begin
			func_q <= req.func;
			key_q  <= req.key[KB-1:0];
			sel_q  <= req.slot_sel;
		end
		if (state_q == ST_PICK) begin
			mid_q <= mid_c;
		end
		if (state_q == ST_HASH) begin
			home_q <= mod_lut[mid_q];
			idx_q  <= mod_lut[mid_q];
			cnt_q  <= '0;
			full_q <= 1'b0;
		end
		if (state_q == ST_PROBE && chk_valid) begin
			if (probe_last) begin
				cnt_q  <= CNT_W'(TABLE_SLOTS);
				full_q <= 1'b1;
				idx_q  <= home_q;
			end else begin
				cnt_q <= cnt_q + 1'b1;
				idx_q <= (idx_q == IDX_W'(TABLE_SLOTS - 1)) ? '0 : idx_q + 1'b1;
			end
		end
	end

	// Assemble the result item
	always_comb begin
		if (func_q == FUNC_READ) begin
			slot_c   = sel_q;
			home_c   = '0;
			occ_c    = sel_ok && chk_valid;
			skey_c   = occ_c ? KEY_W'(rd_key) : '0;
			probes_c = '0;
			full_c   = 1'b0;
		end else begin
			slot_c   = SLOT_W'(idx_q);
			home_c   = SLOT_W'(home_q);
			occ_c    = 1'b1;
			skey_c   = full_q ? KEY_W'(rd_key) : KEY_W'(key_q);
			probes_c = PROBE_W'(cnt_q);
			full_c   = full_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			slot_q      <= slot_c;
			home_slot_q <= home_c;
			skey_q      <= skey_c;
			occ_q       <= occ_c;
			probes_q    <= probes_c;
			tfull_q     <= full_c;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.slot        = slot_q;
	assign rsp.home_slot   = home_slot_q;
	assign rsp.stored_key  = skey_q;
	assign rsp.occupied    = occ_q;
	assign rsp.probe_count = probes_q;
	assign rsp.table_full  = tfull_q;

	msh_bcd_unit #(
		.IN_W (SQ_W)
	) u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.value  (sq_c),
		.stat   (bcd_stat),
		.digits (digits)
	);

	msh_slot_table #(
		.TABLE_SLOTS (TABLE_SLOTS),
		.KEY_BITS    (KB),
		.IDX_W       (IDX_W)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (tbl_ctl),
		.wr_idx    (idx_q),
		.wr_key    (key_q),
		.rd_idx    (rd_idx),
		.rd_key    (rd_key),
		.chk_idx   (chk_idx),
		.chk_valid (chk_valid)
	);

	// A result appears only after the sequencer finished an item
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the final state");

	// The probe never runs past the table size
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> cnt_q < CNT_W'(TABLE_SLOTS))
		else $error("probe count beyond table size");

	// A full table reports every slot probed at an occupied home slot
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.table_full |-> rsp.occupied
			&& rsp.probe_count == PROBE_W'(TABLE_SLOTS))
		else $error("inconsistent table-full result");

endmodule
`default_nettype wire
